[hw/rtl/msd_pkg.sv]
// shared types and constants for the stereo downmix block
package msd_pkg;

  localparam int SAMPLE_W = 24;
  localparam int OUT_W    = 26;
  localparam int SUM_W    = 29;
  localparam int CFG_W    = 6;
  localparam int GAIN_W   = 17;
  localparam int PROD_W   = SAMPLE_W + GAIN_W;
  localparam int GAIN_SH  = 16;
  localparam int DIV_CW   = $clog2(SUM_W);

  // 0.707 as 46334 / 65536
  localparam logic [GAIN_W-1:0] GAIN_NUM = 17'd46334;

  // channel positions used by the surround modes
  localparam int CH_FL  = 0;
  localparam int CH_FR  = 1;
  localparam int CH_FC  = 2;
  localparam int CH_BL  = 4;
  localparam int CH_BR  = 5;
  localparam int CH_SL  = 6;
  localparam int CH_SR  = 7;

  localparam int N_51 = 6;
  localparam int N_71 = 8;

  typedef enum logic [2:0] {
    MODE_MONO,
    MODE_STEREO,
    MODE_51,
    MODE_71,
    MODE_AVG
  } msd_mode_e;

  typedef struct packed {
    logic cfg_we;
    logic take;
    logic mult;
    logic acc;
    logic div_load;
    logic div_step;
    logic finish;
  } msd_cmd_t;

  typedef struct packed {
    msd_mode_e mode;
    logic      last;
    logic      out_busy;
  } msd_stat_t;

endpackage

[hw/rtl/msd_ctrl.sv]
// sequencer for the stereo downmix: one sample at a time, then frame result
module msd_ctrl
  import msd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  msd_stat_t stat_i,
  output msd_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DLOAD,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e              state_q;
  logic   [DIV_CW-1:0] step_q;

  logic idle;
  logic in_xfer;

  assign idle        = (state_q == ST_IDLE);
  assign cfg_ready_o = idle;
  // config has priority over a sample offered in the same cycle
  assign in_stall_o  = !idle || cfg_valid_i;
  assign in_xfer     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (!stat_i.last) begin
            state_q <= ST_IDLE;
          end else if (stat_i.mode == MODE_AVG) begin
            state_q <= ST_DLOAD;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_DLOAD: begin
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + DIV_CW'(1);
          if (step_q == DIV_CW'(SUM_W - 1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!stat_i.out_busy) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.cfg_we   = cfg_valid_i && cfg_ready_o;
    cmd_o.take     = in_xfer;
    cmd_o.mult     = (state_q == ST_MUL);
    cmd_o.acc      = (state_q == ST_ACC);
    cmd_o.div_load = (state_q == ST_DLOAD);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.finish   = (state_q == ST_FIN) && !stat_i.out_busy;
  end

endmodule

[hw/rtl/msd_dpath.sv]
// downmix datapath: gain multiply, frame sums, serial divider, output register
module msd_dpath
  import msd_pkg::*;
#(
  parameter int MAX_CHANNELS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  msd_cmd_t                   cmd_i,
  output msd_stat_t                  stat_o,
  input  logic        [CFG_W-1:0]    cfg_data_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OUT_W-1:0]    left_out_o,
  output logic signed [OUT_W-1:0]    right_out_o
);

  localparam int IW = $clog2(MAX_CHANNELS);
  localparam int NW = $clog2(MAX_CHANNELS + 1);
  localparam int CW = (CFG_W + 1 > NW) ? CFG_W + 1 : NW;

  logic        [CFG_W-1:0]    cnt_q;
  logic        [IW-1:0]       idx_q;
  logic signed [SAMPLE_W-1:0] samp_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [SUM_W-1:0]    lsum_q, rsum_q;
  logic        [SUM_W-1:0]    lq_q, rq_q;
  logic        [NW-1:0]       lr_q, rr_q;
  logic                       lneg_q, rneg_q;
  logic                       out_valid_q;
  logic signed [OUT_W-1:0]    out_l_q, out_r_q;

  logic [CW-1:0] n_raw;
  logic [NW-1:0] n_eff;
  logic [NW-1:0] ch_n;
  logic [IW-1:0] ch;
  logic          last;
  msd_mode_e     mode;

  always_comb begin
    n_raw = (cnt_q == '0) ? CW'(1) : CW'(cnt_q);
    if (n_raw > CW'(MAX_CHANNELS)) begin
      n_raw = CW'(MAX_CHANNELS);
    end
    n_eff = NW'(n_raw);
  end

  always_comb begin
    if (n_eff == NW'(1)) begin
      mode = MODE_MONO;
    end else if (n_eff == NW'(2)) begin
      mode = MODE_STEREO;
    end else if (n_eff == NW'(N_51)) begin
      mode = MODE_51;
    end else if (n_eff == NW'(N_71)) begin
      mode = MODE_71;
    end else begin
      mode = MODE_AVG;
    end
  end

  // a stale index past the frame length restarts the frame
  assign ch   = (NW'(idx_q) >= n_eff) ? '0 : idx_q;
  assign ch_n = NW'(ch) + NW'(1);
  assign last = (ch_n == n_eff);

  assign stat_o.mode     = mode;
  assign stat_o.last     = last;
  assign stat_o.out_busy = out_valid_q && out_stall_i;

  // accumulate terms
  logic signed [SUM_W-1:0] s_ext, g_ext, add_l, add_r, base_l, base_r;

  assign s_ext  = SUM_W'(samp_q);
  assign g_ext  = SUM_W'($signed(prod_q[PROD_W-1:GAIN_SH]));
  assign base_l = (ch == '0) ? '0 : lsum_q;
  assign base_r = (ch == '0) ? '0 : rsum_q;

  always_comb begin
    add_l = '0;
    add_r = '0;
    case (mode)
      MODE_51: begin
        case (ch)
          IW'(CH_FL): add_l = s_ext;
          IW'(CH_FR): add_r = s_ext;
          IW'(CH_FC): begin
            add_l = g_ext;
            add_r = g_ext;
          end
          IW'(CH_BL): add_l = g_ext;
          IW'(CH_BR): add_r = g_ext;
          default: ;
        endcase
      end
      MODE_71: begin
        // sums hold twice the value so the final halving floors once
        case (ch)
          IW'(CH_FL): add_l = s_ext <<< 1;
          IW'(CH_FR): add_r = s_ext <<< 1;
          IW'(CH_FC): begin
            add_l = g_ext <<< 1;
            add_r = g_ext <<< 1;
          end
          IW'(CH_BL), IW'(CH_SL): add_l = s_ext;
          IW'(CH_BR), IW'(CH_SR): add_r = s_ext;
          default: ;
        endcase
      end
      default: begin
        if (ch[0]) begin
          add_r = s_ext;
        end else begin
          add_l = s_ext;
        end
      end
    endcase
  end

  // divider trial subtracts, both lanes each cycle
  logic [NW-1:0] dl, dr;
  logic [NW:0]   tl, tr;
  logic          bl, br;

  assign dl = NW'((CW'(n_eff) + CW'(1)) >> 1);
  assign dr = n_eff >> 1;
  assign tl = {lr_q, lq_q[SUM_W-1]};
  assign tr = {rr_q, rq_q[SUM_W-1]};
  assign bl = (tl >= {1'b0, dl});
  assign br = (tr >= {1'b0, dr});

  // result selection
  logic signed [SUM_W-1:0] res_l, res_r;

  always_comb begin
    case (mode)
      MODE_MONO: begin
        res_l = s_ext;
        res_r = s_ext;
      end
      MODE_71: begin
        res_l = lsum_q >>> 1;
        res_r = rsum_q >>> 1;
      end
      MODE_AVG: begin
        res_l = lneg_q ? -$signed(lq_q) : $signed(lq_q);
        res_r = rneg_q ? -$signed(rq_q) : $signed(rq_q);
      end
      default: begin
        res_l = lsum_q;
        res_r = rsum_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= CFG_W'(2);
      idx_q       <= '0;
      lsum_q      <= '0;
      rsum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cfg_we) begin
        cnt_q  <= cfg_data_i;
        idx_q  <= '0;
        lsum_q <= '0;
        rsum_q <= '0;
      end else if (cmd_i.acc) begin
        lsum_q <= base_l + add_l;
        rsum_q <= base_r + add_r;
        idx_q  <= last ? '0 : IW'(ch_n);
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      samp_q <= sample_i;
    end
    if (cmd_i.mult) begin
      prod_q <= PROD_W'(samp_q) * PROD_W'($signed({1'b0, GAIN_NUM[GAIN_W-2:0]}));
    end
    if (cmd_i.div_load) begin
      lneg_q <= lsum_q[SUM_W-1];
      rneg_q <= rsum_q[SUM_W-1];
      lq_q   <= lsum_q[SUM_W-1] ? SUM_W'(-lsum_q) : SUM_W'(lsum_q);
      rq_q   <= rsum_q[SUM_W-1] ? SUM_W'(-rsum_q) : SUM_W'(rsum_q);
      lr_q   <= '0;
      rr_q   <= '0;
    end else if (cmd_i.div_step) begin
      lr_q <= bl ? NW'(tl - {1'b0, dl}) : NW'(tl);
      rr_q <= br ? NW'(tr - {1'b0, dr}) : NW'(tr);
      lq_q <= {lq_q[SUM_W-2:0], bl};
      rq_q <= {rq_q[SUM_W-2:0], br};
    end
    if (cmd_i.finish) begin
      out_l_q <= res_l[OUT_W-1:0];
      out_r_q <= res_r[OUT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_out_o  = out_l_q;
  assign right_out_o = out_r_q;

endmodule

[hw/rtl/multichannel_stereo_downmix_top.sv]
// stereo downmix top level: controller plus datapath
//
//   channel  dir  signals                                  transfer when
//   in       in   in_valid_i, in_stall_o, sample_i         valid & !stall
//   out      out  out_valid_o, out_stall_i, left/right_out valid & !stall
//   cfg      in   cfg_valid_i, cfg_ready_o, cfg_data_i     valid & ready
//
// each sample is taken, gain multiplied, then accumulated; the last
// sample of a frame then loads the output register, or in averaging mode
// first runs two restoring dividers, one per side, each retiring one quotient
// bit per cycle. reset is asynchronous, active low, channel count 2.
// the output register lets the next sample be taken while a result is stalled;
// a new result waits only while the previous one is still held.
module multichannel_stereo_downmix_top
  import msd_pkg::*;
#(
  parameter int MAX_CHANNELS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [OUT_W-1:0]    left_out_o,
  output logic signed [OUT_W-1:0]    right_out_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic        [CFG_W-1:0]    cfg_data_i
);

  msd_cmd_t  cmd;
  msd_stat_t stat;

  msd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  msd_dpath #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o)
  );

  // a taken sample keeps the input busy while it is processed
  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after sample transfer");

  // the input only opens when config could also be taken
  a_idle_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> cfg_ready_o)
    else $error("input open while config port blocked");

  // a new result comes only from a busy cycle
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a preceding busy cycle");

endmodule

[tb/msd_checker.sv]
// checker for the stereo downmix block: predicts each frame's stereo pair and compares
`timescale 1ns / 100ps
module msd_checker
  import msd_pkg::*;
#(
  parameter int MAX_CHANNELS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic signed [OUT_W-1:0]    left_out_i,
  input  logic signed [OUT_W-1:0]    right_out_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic        [CFG_W-1:0]    cfg_data_i,
  output int                         results_due_o,
  output int                         mismatches_o
);

  localparam logic [CFG_W-1:0] COUNT_AT_RESET = CFG_W'(2);

  typedef struct packed {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
  } stereo_t;

  stereo_t          stereo_q[$];
  logic [CFG_W-1:0] chan_count;
  int               chan_pos;
  longint           left_acc;
  longint           right_acc;
  int               mismatch_count;

  function automatic msd_mode_e mode_of(int n);
    if (n == 1) return MODE_MONO;
    if (n == 2) return MODE_STEREO;
    if (n == N_51) return MODE_51;
    if (n == N_71) return MODE_71;
    return MODE_AVG;
  endfunction

  // gain of 0.707, product floored
  function automatic longint scale_707(longint v);
    return (v * longint'(GAIN_NUM)) >>> GAIN_SH;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp_out(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (OUT_W - 1)) - 1;
    lo = -(longint'(1) <<< (OUT_W - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OUT_W-1:0];
  endfunction

  function automatic void clear_frame();
    chan_pos  = 0;
    left_acc  = 0;
    right_acc = 0;
  endfunction

  function automatic void mix_sample(logic signed [SAMPLE_W-1:0] s);
    int        n;
    int        pos;
    longint    v;
    longint    g;
    msd_mode_e mode;
    stereo_t   res;
    if (chan_count == 0) n = 1;
    else if (int'(chan_count) > MAX_CHANNELS) n = MAX_CHANNELS;
    else n = int'(chan_count);
    mode = mode_of(n);
    v    = longint'(s);
    g    = scale_707(v);
    if (mode == MODE_MONO) begin
      clear_frame();
      res.left  = clamp_out(v);
      res.right = clamp_out(v);
      stereo_q.push_back(res);
      return;
    end
    pos = (chan_pos >= n) ? 0 : chan_pos;
    if (pos == 0) begin
      left_acc  = 0;
      right_acc = 0;
    end
    case (mode)
      MODE_51: begin
        if (pos == CH_FL) left_acc += v;
        else if (pos == CH_FR) right_acc += v;
        else if (pos == CH_FC) begin
          left_acc  += g;
          right_acc += g;
        end
        else if (pos == CH_BL) left_acc += g;
        else if (pos == CH_BR) right_acc += g;
      end
      // sums held doubled so the final halving floors once
      MODE_71: begin
        if (pos == CH_FL) left_acc += 2 * v;
        else if (pos == CH_FR) right_acc += 2 * v;
        else if (pos == CH_FC) begin
          left_acc  += 2 * g;
          right_acc += 2 * g;
        end
        else if (pos == CH_BL || pos == CH_SL) left_acc += v;
        else if (pos == CH_BR || pos == CH_SR) right_acc += v;
      end
      default: begin
        if (pos % 2 == 0) left_acc += v;
        else right_acc += v;
      end
    endcase
    if (pos + 1 != n) begin
      chan_pos = pos + 1;
      return;
    end
    case (mode)
      MODE_71: begin
        res.left  = clamp_out(left_acc >>> 1);
        res.right = clamp_out(right_acc >>> 1);
      end
      // signed division, truncating toward zero
      MODE_AVG: begin
        res.left  = clamp_out(left_acc / longint'((n + 1) / 2));
        res.right = clamp_out(right_acc / longint'(n / 2));
      end
      default: begin
        res.left  = clamp_out(left_acc);
        res.right = clamp_out(right_acc);
      end
    endcase
    clear_frame();
    stereo_q.push_back(res);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_result();
    stereo_t want;
    if (stereo_q.size() == 0) begin
      report_mismatch($sformatf("result L=%0d R=%0d with no frame pending",
                                left_out_i, right_out_i));
      return;
    end
    want = stereo_q.pop_front();
    if (left_out_i !== want.left)
      report_mismatch($sformatf("left_out %0d, predicted %0d", left_out_i, want.left));
    if (right_out_i !== want.right)
      report_mismatch($sformatf("right_out %0d, predicted %0d", right_out_i, want.right));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count     = COUNT_AT_RESET;
      clear_frame();
      stereo_q.delete();
      mismatch_count = 0;
      results_due_o  <= 0;
      mismatches_o   <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      // a register write also starts a new frame
      if (cfg_valid_i && cfg_ready_i) begin
        chan_count = cfg_data_i;
        clear_frame();
      end
      if (in_valid_i && !in_stall_i) mix_sample(sample_i);
      results_due_o <= stereo_q.size();
      mismatches_o  <= mismatch_count;
    end
  end

endmodule

[tb/multichannel_stereo_downmix_top_tb.sv]
// testbench top for the stereo downmix block: stimulus, idle patterns, watchdog and verdict
`timescale 1ns / 100ps
module multichannel_stereo_downmix_top_tb;
  import msd_pkg::*;

  localparam int MAX_CHANNELS  = 32;
  localparam int RANDOM_ITEMS  = 550;
  localparam int SETTLE_CYCLES = 50;
  localparam int QUIET_LIMIT   = 2000;

  localparam logic signed [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] S_ALT = SAMPLE_W'(32'h555555);

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_STALL, IDLE_BOTH} idle_mode_e;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       in_valid_i  = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_i    = '0;
  logic                       out_stall_i = 1'b0;
  logic                       cfg_valid_i = 1'b0;
  logic        [CFG_W-1:0]    cfg_data_i  = '0;
  logic                       in_stall_o;
  logic                       out_valid_o;
  logic                       cfg_ready_o;
  logic signed [OUT_W-1:0]    left_out_o;
  logic signed [OUT_W-1:0]    right_out_o;

  int results_due;
  int mismatches;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int samples_sent  = 0;

  multichannel_stereo_downmix_top #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_out_o  (left_out_o),
    .right_out_o (right_out_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  msd_checker #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .sample_i      (sample_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .left_out_i    (left_out_o),
    .right_out_i   (right_out_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .results_due_o (results_due),
    .mismatches_o  (mismatches)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic set_idle(idle_mode_e m);
    case (m)
      IDLE_NONE: begin
        send_idle_pct = 0;
        stall_pct    <= 0;
      end
      IDLE_SEND: begin
        send_idle_pct = 64;
        stall_pct    <= 0;
      end
      IDLE_STALL: begin
        send_idle_pct = 0;
        stall_pct    <= 64;
      end
      default: begin
        send_idle_pct = 15;
        stall_pct    <= 15;
      end
    endcase
  endtask

  task automatic push_sample(logic signed [SAMPLE_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i   <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    samples_sent++;
  endtask

  // hold off the sender until every predicted pair has been taken
  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
  endtask

  task automatic write_count(logic [CFG_W-1:0] n);
    wait_results();
    // a partial frame may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(15))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_count();
    case ($urandom_range(9))
      0:       return CFG_W'(1);
      1:       return CFG_W'(0);
      2, 3:    return CFG_W'(2);
      4:       return CFG_W'(N_51);
      5:       return CFG_W'(N_71);
      6, 7:    return CFG_W'($urandom_range(3, 12));
      8:       return CFG_W'($urandom_range(13, 32));
      default: return CFG_W'($urandom_range(33, 63));
    endcase
  endfunction

  // whole frames with random content, sometimes a broken frame at the end
  task automatic run_phase(int phase_no, logic [CFG_W-1:0] count);
    int frame_len;
    int frames;
    int tail;
    int pause_at;
    if (count == 0) frame_len = 1;
    else if (int'(count) > MAX_CHANNELS) frame_len = MAX_CHANNELS;
    else frame_len = int'(count);
    frames   = (frame_len > 8) ? $urandom_range(1, 3) : $urandom_range(2, 10);
    tail     = (frame_len > 1 && $urandom_range(3) == 0) ? $urandom_range(1, frame_len - 1) : 0;
    pause_at = (phase_no == 0 || $urandom_range(2) == 0) ? (frames / 2) * frame_len + 1 : -1;
    write_count(count);
    set_idle(idle_mode_e'(phase_no % 4));
    for (int i = 0; i < frames * frame_len + tail; i++) begin
      if (i == pause_at) wait_results();
      push_sample(pick_sample());
    end
  endtask

  initial begin : stimulus
    int phase_no;
    int directed_sent;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // stereo after reset
    push_sample(S_MAX);
    push_sample(S_MIN);
    push_sample('1);
    push_sample(SAMPLE_W'(1));
    // mono, then a zero count that acts as mono
    write_count(CFG_W'(1));
    push_sample(S_MAX);
    push_sample(S_MIN);
    push_sample('1);
    write_count(CFG_W'(0));
    push_sample(S_ALT);
    push_sample(~S_ALT);
    // 5.1 with the lfe at full scale
    write_count(CFG_W'(N_51));
    push_sample(S_MAX);
    push_sample(S_MIN);
    push_sample(S_MIN);
    push_sample(S_MAX);
    push_sample('1);
    push_sample(S_MAX);
    write_count(CFG_W'(N_71));
    push_sample(S_MAX);
    push_sample(S_MIN);
    push_sample('1);
    push_sample(SAMPLE_W'(12345));
    push_sample(S_MAX);
    push_sample(S_MIN);
    push_sample(S_MAX);
    push_sample(S_MIN);
    directed_sent = samples_sent;

    phase_no = 0;
    while (samples_sent - directed_sent < RANDOM_ITEMS) begin
      case (phase_no)
        0:       run_phase(phase_no, CFG_W'(3));
        1:       run_phase(phase_no, CFG_W'(63));
        2:       run_phase(phase_no, CFG_W'(MAX_CHANNELS));
        3:       run_phase(phase_no, CFG_W'(N_51));
        4:       run_phase(phase_no, CFG_W'(N_71));
        5:       run_phase(phase_no, CFG_W'(0));
        6:       run_phase(phase_no, CFG_W'(1));
        7:       run_phase(phase_no, CFG_W'(2));
        default: run_phase(phase_no, pick_count());
      endcase
      phase_no++;
    end

    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && results_due == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // ends the run once no channel has moved a transfer for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
hw/rtl/msd_pkg.sv
hw/rtl/msd_ctrl.sv
hw/rtl/msd_dpath.sv
hw/rtl/multichannel_stereo_downmix_top.sv
tb/msd_checker.sv
tb/multichannel_stereo_downmix_top_tb.sv
